// File: rtl/bsp_pkg.sv
// shared widths, codes and limits of the box screen projection block
`default_nettype none
package bsp_pkg;

   localparam int COORD_W   = 24;
   localparam int CORNER_W  = 25;
   localparam int COEF_W    = 32;
   localparam int PROD_W    = 57;
   localparam int ROW_W     = 59;
   localparam int NUM_W     = 60;
   localparam int SQF_W     = 2 * CORNER_W;
   localparam int SQ_W      = 49;
   localparam int DIST_W    = 51;
   localparam int DIV_W     = 76;
   localparam int QBITS     = 15;
   localparam int SCALE_W   = 14;
   localparam int PIX_W     = 16;
   localparam int NUM_CSR   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 64;
   localparam int NUM_CRN   = 8;
   localparam int DIV_LAT   = 20;

   localparam logic signed [PIX_W-1:0] PIX_MAX = 16'sh7fff;
   localparam logic signed [PIX_W-1:0] PIX_MIN = 16'sh8000;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_FAR    = 2'd1,
      STAT_BEHIND = 2'd2
   } status_type;

endpackage
`default_nettype wire

// File: rtl/bsp_scale_div.sv
// pipelined floor(scale * num / den) with 16-bit saturation, one result per cycle while en is high
`default_nettype none
module bsp_scale_div (
   input  wire logic                                clock,
   input  wire logic                                en,
   input  wire logic [bsp_pkg::SCALE_W-1:0]         scale,
   input  wire logic signed [bsp_pkg::NUM_W-1:0]    num,
   input  wire logic [bsp_pkg::NUM_W-1:0]           den,
   output logic signed [bsp_pkg::PIX_W-1:0]         pix
);
   localparam int NW = bsp_pkg::NUM_W;
   localparam int DW = bsp_pkg::DIV_W;
   localparam int QB = bsp_pkg::QBITS;
   localparam int SW = bsp_pkg::SCALE_W;
   localparam int PW = bsp_pkg::PIX_W;
   localparam int LOW_W = SW + 32;
   localparam int HIGH_W = SW + NW - 32;

   localparam logic signed [PW-1:0] PIX_MIN_L = bsp_pkg::PIX_MIN;
   localparam logic signed [PW-1:0] PIX_MAX_L = bsp_pkg::PIX_MAX;

   logic [NW-1:0]     mag_ff;
   logic              neg_a_ff;
   logic [NW-1:0]     den_a_ff;
   logic [LOW_W-1:0]  lo_ff;
   logic [HIGH_W-1:0] hi_ff;
   logic              neg_b_ff;
   logic [NW-1:0]     den_b_ff;
   logic [DW-1:0]     prod_ff;
   logic              neg_c_ff;
   logic [NW-1:0]     den_c_ff;

   logic [DW-1:0]     rem_ff [0:QB];
   logic [QB-1:0]     quo_ff [0:QB];
   logic              neg_ff [0:QB];
   logic              ovf_ff [0:QB];
   logic [NW-1:0]     dv_ff  [0:QB];

   logic [DW-1:0]     trial [0:QB-1];
   logic              take  [0:QB-1];

   logic [PW:0]             adj;
   logic signed [PW-1:0]    pix_in;
   logic signed [PW-1:0]    pix_ff;

   // restoring steps, most significant quotient bit first
   always_comb begin
      for (int s = 0; s < QB; s++) begin
         trial[s] = DW'(dv_ff[s]) << (QB - 1 - s);
         take[s]  = rem_ff[s] >= trial[s];
      end
   end

   always_comb begin
      adj = (PW+1)'(quo_ff[QB]) + (PW+1)'(rem_ff[QB] != '0);
      if (ovf_ff[QB]) begin
         pix_in = neg_ff[QB] ? PIX_MIN_L : PIX_MAX_L;
      end else if (neg_ff[QB]) begin
         pix_in = PW'(-adj);
      end else begin
         pix_in = PW'(quo_ff[QB]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // magnitude and sign
         neg_a_ff <= num[NW-1];
         mag_ff   <= num[NW-1] ? (NW'(~num) + NW'(1)) : NW'(num);
         den_a_ff <= den;
         // two partial products of scale by magnitude
         lo_ff    <= LOW_W'(scale) * LOW_W'(mag_ff[31:0]);
         hi_ff    <= HIGH_W'(scale) * HIGH_W'(mag_ff[NW-1:32]);
         neg_b_ff <= neg_a_ff;
         den_b_ff <= den_a_ff;
         // dividend
         prod_ff  <= (DW'(hi_ff) << 32) + DW'(lo_ff);
         neg_c_ff <= neg_b_ff;
         den_c_ff <= den_b_ff;
         // quotient of 2^15 or more saturates
         rem_ff[0] <= prod_ff;
         quo_ff[0] <= '0;
         neg_ff[0] <= neg_c_ff;
         ovf_ff[0] <= prod_ff >= (DW'(den_c_ff) << QB);
         dv_ff[0]  <= den_c_ff;
         for (int s = 0; s < QB; s++) begin
            rem_ff[s+1] <= take[s] ? (rem_ff[s] - trial[s]) : rem_ff[s];
            quo_ff[s+1] <= {quo_ff[s][QB-2:0], take[s]};
            neg_ff[s+1] <= neg_ff[s];
            ovf_ff[s+1] <= ovf_ff[s];
            dv_ff[s+1]  <= dv_ff[s];
         end
         pix_ff <= pix_in;
      end
   end

   assign pix = pix_ff;

endmodule
`default_nettype wire

// File: rtl/box_screen_projection_unit.sv
// top level of the box screen projection block
`default_nettype none
// Takes one box per cycle (origin, lower and upper corner offsets, viewer position, all Q16.8)
// and returns one transaction per box: status 1 when the origin lies beyond the draw distance,
// status 2 when any of the eight corners has depth or w not above zero, otherwise status 0 and
// the saturated pixel rectangle enclosing the projected corners. The matrix lives in eight
// 64-bit csr registers (two Q16.16 coefficients each, low word first) written on csr_we.
// Throughput is one box per cycle while the output is not held; the registers in order are the
// input register, products, row sums, cull and numerator stage, the pipelined divider (one
// quotient bit per restoring step), two min/max levels and the output register. A held output
// freezes the whole pipe, so req_ready is low exactly while a result waits and rsp_ready is low.
module box_screen_projection_unit #(
   parameter int SCREEN_WIDTH      = 1920,
   parameter int SCREEN_HEIGHT     = 1080,
   parameter int MAX_DRAW_DISTANCE = 8192
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [bsp_pkg::COORD_W-1:0]     req_origin_x,
   input  wire logic signed [bsp_pkg::COORD_W-1:0]     req_origin_y,
   input  wire logic signed [bsp_pkg::COORD_W-1:0]     req_origin_z,
   input  wire logic signed [bsp_pkg::COORD_W-1:0]     req_min_off_x,
   input  wire logic signed [bsp_pkg::COORD_W-1:0]     req_min_off_y,
   input  wire logic signed [bsp_pkg::COORD_W-1:0]     req_min_off_z,
   input  wire logic signed [bsp_pkg::COORD_W-1:0]     req_max_off_x,
   input  wire logic signed [bsp_pkg::COORD_W-1:0]     req_max_off_y,
   input  wire logic signed [bsp_pkg::COORD_W-1:0]     req_max_off_z,
   input  wire logic signed [bsp_pkg::COORD_W-1:0]     req_viewer_x,
   input  wire logic signed [bsp_pkg::COORD_W-1:0]     req_viewer_y,
   input  wire logic signed [bsp_pkg::COORD_W-1:0]     req_viewer_z,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [1:0]                                  rsp_status,
   output logic signed [bsp_pkg::PIX_W-1:0]            rsp_rect_left,
   output logic signed [bsp_pkg::PIX_W-1:0]            rsp_rect_top,
   output logic signed [bsp_pkg::PIX_W-1:0]            rsp_rect_right,
   output logic signed [bsp_pkg::PIX_W-1:0]            rsp_rect_bottom,
   input  wire logic                                   csr_we,
   input  wire logic [bsp_pkg::CSR_IDX_W-1:0]          csr_addr,
   input  wire logic [bsp_pkg::CSR_W-1:0]              csr_wdata
);
   localparam int CW  = bsp_pkg::CORNER_W;
   localparam int PRW = bsp_pkg::PROD_W;
   localparam int RW  = bsp_pkg::ROW_W;
   localparam int NW  = bsp_pkg::NUM_W;
   localparam int SQF = bsp_pkg::SQF_W;
   localparam int SQW = bsp_pkg::SQ_W;
   localparam int DSW = bsp_pkg::DIST_W;
   localparam int PW  = bsp_pkg::PIX_W;
   localparam int NC  = bsp_pkg::NUM_CRN;
   localparam int DL  = bsp_pkg::DIV_LAT;
   localparam int SW  = bsp_pkg::SCALE_W;

   // squared draw distance in Q.16
   localparam logic [DSW-1:0] DRAW_Q   = DSW'(MAX_DRAW_DISTANCE) << 8;
   localparam logic [DSW-1:0] DRAW_LIM = DRAW_Q * DRAW_Q;

   // pipe moves whenever the output register is empty or being drained
   logic advance;

   // matrix registers and coefficient view
   logic [bsp_pkg::CSR_W-1:0]            csr_ff [0:bsp_pkg::NUM_CSR-1];
   logic signed [bsp_pkg::COEF_W-1:0]    coef [0:3][0:3];

   // input side gathered into arrays
   logic signed [bsp_pkg::COORD_W-1:0]   org [0:2];
   logic signed [bsp_pkg::COORD_W-1:0]   off_lo [0:2];
   logic signed [bsp_pkg::COORD_W-1:0]   off_hi [0:2];
   logic signed [bsp_pkg::COORD_W-1:0]   view [0:2];

   // stage 0: corner bounds and viewer distance
   logic                  s0_valid_ff;
   logic signed [CW-1:0]  lo_ff [0:2];
   logic signed [CW-1:0]  hi_ff [0:2];
   logic signed [CW-1:0]  diff_ff [0:2];

   // stage 1: products
   logic                  s1_valid_ff;
   logic signed [PRW-1:0] prod_ff [0:NC-1][0:3][0:2];
   logic signed [SQF-1:0] sq_full [0:2];
   logic [SQW-1:0]        sq_ff [0:2];

   // stage 2: row sums
   logic                  s2_valid_ff;
   logic signed [RW-1:0]  row_ff [0:NC-1][0:3];
   logic [DSW-1:0]        dist_ff;

   // stage 3: cull decision and divider operands
   logic                           behind;
   logic                           s3_valid_ff;
   bsp_pkg::status_type            s3_status_ff;
   bsp_pkg::status_type            s3_status_in;
   logic signed [NW-1:0]           numx_ff [0:NC-1];
   logic signed [NW-1:0]           numy_ff [0:NC-1];
   logic [NW-1:0]                  den_ff [0:NC-1];

   // divider results and the matching control delay line
   logic signed [PW-1:0]           px [0:NC-1];
   logic signed [PW-1:0]           py [0:NC-1];
   logic                           dl_valid_ff [0:DL-1];
   bsp_pkg::status_type            dl_status_ff [0:DL-1];

   // min/max tree
   logic                           l1_valid_ff;
   bsp_pkg::status_type            l1_status_ff;
   logic signed [PW-1:0]           l1_left_ff [0:3];
   logic signed [PW-1:0]           l1_right_ff [0:3];
   logic signed [PW-1:0]           l1_top_ff [0:3];
   logic signed [PW-1:0]           l1_bot_ff [0:3];
   logic                           l2_valid_ff;
   bsp_pkg::status_type            l2_status_ff;
   logic signed [PW-1:0]           l2_left_ff [0:1];
   logic signed [PW-1:0]           l2_right_ff [0:1];
   logic signed [PW-1:0]           l2_top_ff [0:1];
   logic signed [PW-1:0]           l2_bot_ff [0:1];

   // output register
   logic                           out_valid_ff;
   bsp_pkg::status_type            out_status_ff;
   logic signed [PW-1:0]           out_left_ff;
   logic signed [PW-1:0]           out_right_ff;
   logic signed [PW-1:0]           out_top_ff;
   logic signed [PW-1:0]           out_bot_ff;
   logic signed [PW-1:0]           fin_left;
   logic signed [PW-1:0]           fin_right;
   logic signed [PW-1:0]           fin_top;
   logic signed [PW-1:0]           fin_bot;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   assign org[0]    = req_origin_x;
   assign org[1]    = req_origin_y;
   assign org[2]    = req_origin_z;
   assign off_lo[0] = req_min_off_x;
   assign off_lo[1] = req_min_off_y;
   assign off_lo[2] = req_min_off_z;
   assign off_hi[0] = req_max_off_x;
   assign off_hi[1] = req_max_off_y;
   assign off_hi[2] = req_max_off_z;
   assign view[0]   = req_viewer_x;
   assign view[1]   = req_viewer_y;
   assign view[2]   = req_viewer_z;

   // csr writes, matrix split into signed words
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bsp_pkg::NUM_CSR; i++) begin
            csr_ff[i] <= '0;
         end
      end else if (csr_we) begin
         csr_ff[csr_addr] <= csr_wdata;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            coef[r][c] = c[0] ? csr_ff[r*2 + c/2][63:32] : csr_ff[r*2 + c/2][31:0];
         end
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sq_full[a] = SQF'(diff_ff[a]) * SQF'(diff_ff[a]);
      end
   end

   // any corner with depth or w at or below zero sends the box behind the camera
   always_comb begin
      behind = 1'b0;
      for (int k = 0; k < NC; k++) begin
         if (row_ff[k][2] <= 0 || row_ff[k][3] <= 0) begin
            behind = 1'b1;
         end
      end
   end

   // distance cull wins over behind camera
   always_comb begin
      if (dist_ff > DRAW_LIM) begin
         s3_status_in = bsp_pkg::STAT_FAR;
      end else if (behind) begin
         s3_status_in = bsp_pkg::STAT_BEHIND;
      end else begin
         s3_status_in = bsp_pkg::STAT_OK;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         for (int i = 0; i < DL; i++) begin
            dl_valid_ff[i] <= 1'b0;
         end
         l1_valid_ff  <= 1'b0;
         l2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff    <= req_valid;
         s1_valid_ff    <= s0_valid_ff;
         s2_valid_ff    <= s1_valid_ff;
         s3_valid_ff    <= s2_valid_ff;
         dl_valid_ff[0] <= s3_valid_ff;
         for (int i = 1; i < DL; i++) begin
            dl_valid_ff[i] <= dl_valid_ff[i-1];
         end
         l1_valid_ff    <= dl_valid_ff[DL-1];
         l2_valid_ff    <= l1_valid_ff;
         out_valid_ff   <= l2_valid_ff;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (advance) begin
         // corners exact in 25 bits
         for (int a = 0; a < 3; a++) begin
            lo_ff[a]   <= CW'(org[a]) + CW'(off_lo[a]);
            hi_ff[a]   <= CW'(org[a]) + CW'(off_hi[a]);
            diff_ff[a] <= CW'(org[a]) - CW'(view[a]);
         end
         // coefficient times corner coordinate, corner k picks hi on axis a when bit a is set
         for (int k = 0; k < NC; k++) begin
            for (int r = 0; r < 4; r++) begin
               for (int a = 0; a < 3; a++) begin
                  prod_ff[k][r][a] <= PRW'(coef[r][a])
                                      * PRW'(k[a] ? hi_ff[a] : lo_ff[a]);
               end
            end
         end
         for (int a = 0; a < 3; a++) begin
            sq_ff[a] <= sq_full[a][SQW-1:0];
         end
         // rows in Q.24
         for (int k = 0; k < NC; k++) begin
            for (int r = 0; r < 4; r++) begin
               row_ff[k][r] <= RW'(prod_ff[k][r][0]) + RW'(prod_ff[k][r][1])
                               + RW'(prod_ff[k][r][2]) + (RW'(coef[r][3]) <<< 8);
            end
         end
         dist_ff <= DSW'(sq_ff[0]) + DSW'(sq_ff[1]) + DSW'(sq_ff[2]);
         // numerators w + x, w - y and denominator 2w
         s3_status_ff <= s3_status_in;
         for (int k = 0; k < NC; k++) begin
            numx_ff[k] <= NW'(row_ff[k][3]) + NW'(row_ff[k][0]);
            numy_ff[k] <= NW'(row_ff[k][3]) - NW'(row_ff[k][1]);
            den_ff[k]  <= NW'(row_ff[k][3]) << 1;
         end
         dl_status_ff[0] <= s3_status_ff;
         for (int i = 1; i < DL; i++) begin
            dl_status_ff[i] <= dl_status_ff[i-1];
         end
         // min/max over corner pairs
         l1_status_ff <= dl_status_ff[DL-1];
         for (int j = 0; j < 4; j++) begin
            l1_left_ff[j]  <= (px[2*j] < px[2*j+1]) ? px[2*j] : px[2*j+1];
            l1_right_ff[j] <= (px[2*j] > px[2*j+1]) ? px[2*j] : px[2*j+1];
            l1_top_ff[j]   <= (py[2*j] < py[2*j+1]) ? py[2*j] : py[2*j+1];
            l1_bot_ff[j]   <= (py[2*j] > py[2*j+1]) ? py[2*j] : py[2*j+1];
         end
         l2_status_ff <= l1_status_ff;
         for (int j = 0; j < 2; j++) begin
            l2_left_ff[j]  <= (l1_left_ff[2*j] < l1_left_ff[2*j+1])
                              ? l1_left_ff[2*j] : l1_left_ff[2*j+1];
            l2_right_ff[j] <= (l1_right_ff[2*j] > l1_right_ff[2*j+1])
                              ? l1_right_ff[2*j] : l1_right_ff[2*j+1];
            l2_top_ff[j]   <= (l1_top_ff[2*j] < l1_top_ff[2*j+1])
                              ? l1_top_ff[2*j] : l1_top_ff[2*j+1];
            l2_bot_ff[j]   <= (l1_bot_ff[2*j] > l1_bot_ff[2*j+1])
                              ? l1_bot_ff[2*j] : l1_bot_ff[2*j+1];
         end
         out_status_ff <= l2_status_ff;
         out_left_ff   <= fin_left;
         out_right_ff  <= fin_right;
         out_top_ff    <= fin_top;
         out_bot_ff    <= fin_bot;
      end
   end

   // last min/max level, rectangle forced to zero for culled boxes
   always_comb begin
      fin_left  = '0;
      fin_right = '0;
      fin_top   = '0;
      fin_bot   = '0;
      if (l2_status_ff == bsp_pkg::STAT_OK) begin
         fin_left  = (l2_left_ff[0] < l2_left_ff[1]) ? l2_left_ff[0] : l2_left_ff[1];
         fin_right = (l2_right_ff[0] > l2_right_ff[1]) ? l2_right_ff[0] : l2_right_ff[1];
         fin_top   = (l2_top_ff[0] < l2_top_ff[1]) ? l2_top_ff[0] : l2_top_ff[1];
         fin_bot   = (l2_bot_ff[0] > l2_bot_ff[1]) ? l2_bot_ff[0] : l2_bot_ff[1];
      end
   end

   // one divider per corner and screen axis
   for (genvar k = 0; k < NC; k++) begin : g_corner
      bsp_scale_div u_div_x (
         .clock (clock),
         .en    (advance),
         .scale (SW'(SCREEN_WIDTH)),
         .num   (numx_ff[k]),
         .den   (den_ff[k]),
         .pix   (px[k])
      );
      bsp_scale_div u_div_y (
         .clock (clock),
         .en    (advance),
         .scale (SW'(SCREEN_HEIGHT)),
         .num   (numy_ff[k]),
         .den   (den_ff[k]),
         .pix   (py[k])
      );
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_rect_left   = out_left_ff;
   assign rsp_rect_top    = out_top_ff;
   assign rsp_rect_right  = out_right_ff;
   assign rsp_rect_bottom = out_bot_ff;

endmodule
`default_nettype wire

// File: rtl/bsp_checker.sv
// port-level checks of the box screen projection block and their bind
`default_nettype none
module bsp_checker (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_ready,
   input  wire logic                                   rsp_valid,
   input  wire logic                                   rsp_ready,
   input  wire logic [1:0]                             rsp_status,
   input  wire logic signed [bsp_pkg::PIX_W-1:0]       rsp_rect_left,
   input  wire logic signed [bsp_pkg::PIX_W-1:0]       rsp_rect_top,
   input  wire logic signed [bsp_pkg::PIX_W-1:0]       rsp_rect_right,
   input  wire logic signed [bsp_pkg::PIX_W-1:0]       rsp_rect_bottom
);
   // a held transaction keeps its status and its left and right edges
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_rect_left) && $stable(rsp_rect_right))
      else $error("rsp payload changed while stalled");

   // culled boxes carry an empty rectangle
   a_cull_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bsp_pkg::STAT_OK |-> rsp_rect_left == 0
         && rsp_rect_top == 0 && rsp_rect_right == 0 && rsp_rect_bottom == 0)
      else $error("culled box with nonzero rectangle");

   // a visible rectangle is ordered
   a_rect_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bsp_pkg::STAT_OK |-> rsp_rect_left <= rsp_rect_right
         && rsp_rect_top <= rsp_rect_bottom)
      else $error("rectangle min above max");

   // input side only stalls behind a waiting result
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output");

endmodule

bind box_screen_projection_unit bsp_checker u_bsp_checker (.*);
`default_nettype wire

// File: tb/tb_box_screen_projection_unit.sv
// self-checking testbench for the box screen projection unit
`default_nettype none
module tb_box_screen_projection_unit;

   // one box request: origin, lower offset, upper offset, viewer (x, y, z each)
   typedef logic signed [bsp_pkg::COORD_W-1:0] box_type [12];

   typedef struct {
      bsp_pkg::status_type                 status;
      logic signed [bsp_pkg::PIX_W-1:0]    left;
      logic signed [bsp_pkg::PIX_W-1:0]    top;
      logic signed [bsp_pkg::PIX_W-1:0]    right;
      logic signed [bsp_pkg::PIX_W-1:0]    bottom;
   } rect_type;

   localparam int  SCREEN_W   = 1920;
   localparam int  SCREEN_H   = 1080;
   localparam int  DRAW_DIST  = 8192;
   localparam int  PIPE_LAT   = 27;
   localparam int  STALL_MAX  = 5000;
   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

   logic clock, reset;
   logic req_valid, req_ready;
   logic signed [bsp_pkg::COORD_W-1:0] req_f [12];
   logic rsp_valid, rsp_ready;
   logic [1:0] rsp_status;
   logic signed [bsp_pkg::PIX_W-1:0] rsp_rect_left, rsp_rect_top;
   logic signed [bsp_pkg::PIX_W-1:0] rsp_rect_right, rsp_rect_bottom;
   logic csr_we;
   logic [bsp_pkg::CSR_IDX_W-1:0] csr_addr;
   logic [bsp_pkg::CSR_W-1:0] csr_wdata;

   // local copy of the matrix registers
   logic [bsp_pkg::CSR_W-1:0] matrix_regs [bsp_pkg::NUM_CSR];

   rect_type pending_rects [$];
   int    errors;
   int    idle_cycles;
   bit    calm;          // no gaps on either side while set

   box_screen_projection_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_origin_x(req_f[0]), .req_origin_y(req_f[1]), .req_origin_z(req_f[2]),
      .req_min_off_x(req_f[3]), .req_min_off_y(req_f[4]), .req_min_off_z(req_f[5]),
      .req_max_off_x(req_f[6]), .req_max_off_y(req_f[7]), .req_max_off_z(req_f[8]),
      .req_viewer_x(req_f[9]), .req_viewer_y(req_f[10]), .req_viewer_z(req_f[11]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_rect_left(rsp_rect_left), .rsp_rect_top(rsp_rect_top),
      .rsp_rect_right(rsp_rect_right), .rsp_rect_bottom(rsp_rect_bottom),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // signed Q16.16 coefficient of one matrix row, low word holds the even column
   function automatic longint coef_at(int row, int col);
      logic [bsp_pkg::CSR_W-1:0] r;
      logic signed [31:0] w;
      r = matrix_regs[row * 2 + col / 2];
      w = (col % 2) ? r[63:32] : r[31:0];
      return longint'(w);
   endfunction

   // row r0*x + r1*y + r2*z + r3, exact in Q.24
   function automatic longint row_eval(int row, longint x, longint y, longint z);
      return coef_at(row, 0) * x + coef_at(row, 1) * y + coef_at(row, 2) * z
           + coef_at(row, 3) * 256;
   endfunction

   // floor(scale * num / den), den > 0, saturated to the pixel range
   function automatic logic signed [bsp_pkg::PIX_W-1:0] pixel_of(longint scale,
                                                                 longint num,
                                                                 longint den);
      logic [127:0] mag, prod, quo, rem;
      longint v;
      mag  = (num < 0) ? 128'(-num) : 128'(num);
      prod = 128'(scale) * mag;
      quo  = prod / 128'(den);
      rem  = prod % 128'(den);
      if (quo > 128'(1 << 20))
         quo = 128'(1 << 20);
      v = (num >= 0) ? longint'(quo) : -(longint'(quo) + (rem != 0 ? 1 : 0));
      if (v > 32767)
         v = 32767;
      if (v < -32768)
         v = -32768;
      return v[bsp_pkg::PIX_W-1:0];
   endfunction

   function automatic rect_type predict_rect(box_type b);
      rect_type res;
      longint   lo [3], hi [3], dv, dist_sq, lim, x, y, z, pz, pw;
      logic signed [bsp_pkg::PIX_W-1:0] px, py;
      res = '{bsp_pkg::STAT_OK, 0, 0, 0, 0};
      dist_sq = 0;
      for (int i = 0; i < 3; i++) begin
         lo[i] = longint'(b[i]) + longint'(b[3 + i]);
         hi[i] = longint'(b[i]) + longint'(b[6 + i]);
         dv = longint'(b[i]) - longint'(b[9 + i]);
         dist_sq += dv * dv;
      end
      lim = longint'(DRAW_DIST) * 256;
      lim = lim * lim;
      if (dist_sq > lim) begin
         res.status = bsp_pkg::STAT_FAR;
         return res;
      end
      for (int k = 0; k < bsp_pkg::NUM_CRN; k++) begin
         x  = (k & 1) ? hi[0] : lo[0];
         y  = (k & 2) ? hi[1] : lo[1];
         z  = (k & 4) ? hi[2] : lo[2];
         pz = row_eval(2, x, y, z);
         pw = row_eval(3, x, y, z);
         if (pz <= 0 || pw <= 0) begin
            res = '{bsp_pkg::STAT_BEHIND, 0, 0, 0, 0};
            return res;
         end
         px = pixel_of(SCREEN_W, pw + row_eval(0, x, y, z), 2 * pw);
         py = pixel_of(SCREEN_H, pw - row_eval(1, x, y, z), 2 * pw);
         if (k == 0 || px < res.left)   res.left   = px;
         if (k == 0 || px > res.right)  res.right  = px;
         if (k == 0 || py < res.top)    res.top    = py;
         if (k == 0 || py > res.bottom) res.bottom = py;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
      errors++;
   endtask

   // check first, then record the newly accepted box: latency keeps them apart
   always @(posedge clock) begin
      rect_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rects.size() == 0) begin
            report_mismatch("transaction with nothing pending, status", rsp_status, -1);
         end else begin
            want = pending_rects.pop_front();
            if (rsp_status != want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_rect_left != want.left)
               report_mismatch("rect_left", rsp_rect_left, want.left);
            if (rsp_rect_top != want.top)
               report_mismatch("rect_top", rsp_rect_top, want.top);
            if (rsp_rect_right != want.right)
               report_mismatch("rect_right", rsp_rect_right, want.right);
            if (rsp_rect_bottom != want.bottom)
               report_mismatch("rect_bottom", rsp_rect_bottom, want.bottom);
         end
      end
      if (!reset && req_valid && req_ready)
         pending_rects.push_back(predict_rect(req_f));
   end

   // watchdog: cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
         $display("watchdog expired at %0t", $time);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   // receiver back-pressure
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         int g;
         g = pick_gap();
         rsp_ready  <= (g == 0);
         stall_left <= (g == 0) ? $urandom_range(0, 6) : g - 1;
      end
   end

   // ---------------------------------------------------------------- driving

   task automatic send_box(box_type b);
      int gap;
      req_valid <= 1'b1;
      foreach (b[i]) req_f[i] <= b[i];
      do @(posedge clock); while (!req_ready);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait until every pending rectangle has come back, then let the pipe settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rects.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 5) @(posedge clock);
   endtask

   task automatic write_matrix_reg(int idx, logic [bsp_pkg::CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= idx[bsp_pkg::CSR_IDX_W-1:0];
      csr_wdata <= data;
      matrix_regs[idx] = data;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // pack a row of four coefficients into its two registers
   task automatic load_row(int row, logic [31:0] a, logic [31:0] b,
                           logic [31:0] c, logic [31:0] d);
      write_matrix_reg(row * 2, {b, a});
      write_matrix_reg(row * 2 + 1, {d, c});
   endtask

   // simple camera looking down +z: x, y pass through, depth and w follow z
   task automatic load_perspective();
      load_row(0, ONE_Q16, 0, 0, 0);
      load_row(1, 0, ONE_Q16, 0, 0);
      load_row(2, 0, 0, ONE_Q16, 0);
      load_row(3, 0, 0, ONE_Q16, 0);
   endtask

   function automatic logic signed [bsp_pkg::COORD_W-1:0] rand_coord(int lo, int hi);
      return bsp_pkg::COORD_W'($urandom_range(0, hi - lo) + lo);
   endfunction

   // a box in front of the camera near the viewer, random content
   function automatic box_type scene_box();
      box_type b;
      int span;
      span = ($urandom_range(0, 9) == 0) ? 4000 : 300;
      b[0] = rand_coord(-span * 256, span * 256);
      b[1] = rand_coord(-span * 256, span * 256);
      b[2] = rand_coord(20 * 256, 3000 * 256);
      for (int i = 0; i < 3; i++) begin
         b[3 + i] = rand_coord(-15 * 256, 2 * 256);
         b[6 + i] = rand_coord(-2 * 256, 15 * 256);
         b[9 + i] = rand_coord(-200 * 256, 200 * 256);
      end
      // now and then a viewer far enough away to cull
      if ($urandom_range(0, 7) == 0)
         b[9] = rand_coord(-8388608, 8388607);
      // now and then a box dipping behind the camera
      if ($urandom_range(0, 7) == 0)
         b[5] = rand_coord(-4000 * 256, 0);
      return b;
   endfunction

   function automatic box_type noise_box();
      box_type b;
      foreach (b[i]) b[i] = bsp_pkg::COORD_W'($urandom());
      return b;
   endfunction

   function automatic box_type mixed_box();
      return ($urandom_range(0, 4) == 0) ? noise_box() : scene_box();
   endfunction

   // ---------------------------------------------------------------- tests

   // matrix still zero after reset: every near box is behind the camera
   task automatic test_reset_matrix();
      box_type b;
      for (int n = 0; n < 4; n++) send_box(scene_box());
      foreach (b[i]) b[i] = '0;
      send_box(b);
      wait_drained();
   endtask

   task automatic test_directed();
      box_type b;
      load_perspective();
      // all fields at their largest, then at their smallest
      foreach (b[i]) b[i] = 24'sh7fffff;
      send_box(b);
      foreach (b[i]) b[i] = 24'sh800000;
      send_box(b);
      // x exactly on the draw distance plus a small depth: culled; one step further: culled
      foreach (b[i]) b[i] = '0;
      b[0] = 24'sd2097152; b[2] = 24'sd256; b[8] = 24'sd256;
      send_box(b);
      b[0] = 24'sd2097153;
      send_box(b);
      // viewer at the opposite extreme
      foreach (b[i]) b[i] = '0;
      b[9] = 24'sh800000; b[10] = 24'sh7fffff;
      send_box(b);
      // plain box in front
      b = '{256, 256, 100 * 256, -256, -256, -256, 256, 256, 256, 0, 0, 0};
      send_box(b);
      // degenerate box, lower offsets above the upper ones
      b = '{0, 0, 50 * 256, 512, 512, 512, -512, -512, -512, 0, 0, 0};
      send_box(b);
      // one corner on the camera plane, one corner behind it
      b = '{0, 0, 256, 0, 0, -256, 0, 0, 256, 0, 0, 0};
      send_box(b);
      b = '{0, 0, 256, 0, 0, -257, 0, 0, 256, 0, 0, 0};
      send_box(b);
      // tiny depth with wide x, then wide y: pixels saturate both ways
      b = '{0, 0, 1, -24'sd2000000, 0, 0, 24'sd2000000, 0, 0, 0, 0, 0};
      send_box(b);
      b = '{0, 0, 1, 0, -24'sd2000000, 0, 0, 24'sd2000000, 0, 0, 0, 0};
      send_box(b);
      // corners sum beyond the 24-bit field
      b = '{24'sd1000000, 24'sd1000000, 24'sd2000000,
            24'sh7fffff, 24'sh7fffff, 24'sh7fffff,
            24'sh7fffff, 24'sh7fffff, 24'sh7fffff,
            24'sd1000000, 24'sd1000000, 24'sd2000000};
      send_box(b);
      wait_drained();
   endtask

   task automatic test_perspective_random();
      load_perspective();
      for (int n = 0; n < 400; n++) begin
         calm = (n >= 100 && n < 160);
         send_box(mixed_box());
         // sender holds off until the pipe is empty once
         if (n == 200)
            wait_drained();
      end
      calm = 0;
      wait_drained();
   endtask

   // camera with random perturbations in every coefficient
   task automatic test_random_matrix();
      for (int phase = 0; phase < 3; phase++) begin
         for (int r = 0; r < 4; r++) begin
            logic [31:0] c [4];
            foreach (c[j]) c[j] = $urandom_range(0, 8191) - 4096;
            if (r < 2) c[r] += ONE_Q16 + $urandom_range(0, 65535);
            else       c[2] += ONE_Q16 + $urandom_range(0, 65535);
            if (r == 3 && phase == 2) c[3] = $urandom();
            load_row(r, c[0], c[1], c[2], c[3]);
         end
         for (int n = 0; n < 90; n++) send_box(mixed_box());
         wait_drained();
      end
   endtask

   // coefficient extremes, then wholly random registers
   task automatic test_extreme_matrix();
      logic [bsp_pkg::CSR_W-1:0] fill [3];
      fill = '{64'h7fffffff_7fffffff, 64'hffffffff_ffffffff, 64'h80000000_80000000};
      foreach (fill[f]) begin
         for (int i = 0; i < bsp_pkg::NUM_CSR; i++) write_matrix_reg(i, fill[f]);
         for (int n = 0; n < 40; n++) send_box(mixed_box());
         wait_drained();
      end
      // depth and w at the most positive value, x and y rows at the most negative
      for (int i = 0; i < 4; i++) write_matrix_reg(i, 64'h80000000_80000000);
      for (int i = 4; i < bsp_pkg::NUM_CSR; i++) write_matrix_reg(i, 64'h7fffffff_7fffffff);
      for (int n = 0; n < 40; n++) send_box(scene_box());
      wait_drained();
      for (int i = 0; i < bsp_pkg::NUM_CSR; i++) write_matrix_reg(i, {$urandom(), $urandom()});
      for (int n = 0; n < 60; n++) send_box(mixed_box());
      wait_drained();
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      errors      = 0;
      calm        = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      foreach (req_f[i]) req_f[i] = '0;
      csr_we      = 1'b0;
      csr_addr    = '0;
      csr_wdata   = '0;
      foreach (matrix_regs[i]) matrix_regs[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_matrix();
      test_directed();
      test_perspective_random();
      test_random_matrix();
      test_extreme_matrix();

      wait_drained();
      repeat (PIPE_LAT + 10) @(posedge clock);
      if (errors == 0 && pending_rects.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
